[sv/rbps_pkg.sv]
`default_nettype none

package rbps_pkg;

	localparam int RING_DEPTH_DEF  = 256;
	localparam int PATTERN_MAX_DEF = 16;

	typedef enum logic [2:0] {
		ACT_RECV    = 3'd0,
		ACT_PATTERN = 3'd1,
		ACT_SEARCH  = 3'd2,
		ACT_EXTRACT = 3'd3,
		ACT_PURGE   = 3'd4
	} action_t;

	typedef struct packed {
		logic       found;
		logic [7:0] match_position;
		logic       is_payload;
		logic [7:0] payload_byte;
		logic       final_item;
	} result_t;

endpackage

`default_nettype wire

[sv/rbps_if.sv]
`default_nettype none

interface rbps_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [7:0] data_value;
	logic [3:0] pattern_slot;
	logic [4:0] pattern_length;
	logic [7:0] stop_byte;
	logic [5:0] copy_limit;

	modport source (output valid, action, data_value, pattern_slot, pattern_length,
		stop_byte, copy_limit, input ready);
	modport sink (input valid, action, data_value, pattern_slot, pattern_length,
		stop_byte, copy_limit, output ready);
endinterface

interface rbps_out_if;
	logic       valid;
	logic       ready;
	logic       found;
	logic [7:0] match_position;
	logic       is_payload;
	logic [7:0] payload_byte;
	logic       final_item;

	modport source (output valid, found, match_position, is_payload, payload_byte,
		final_item, input ready);
	modport sink (input valid, found, match_position, is_payload, payload_byte,
		final_item, output ready);
endinterface

`default_nettype wire

[sv/ring_buffer_pattern_search.sv]
`default_nettype none

// Channel  Dir  Word
// rx       in   action, data_value, pattern_slot, pattern_length, stop_byte, copy_limit
// tx       out  found, match_position, is_payload, payload_byte, final_item
//
// Receive, pattern load and purge are done in the idle state when accepted.
// A search compares byte by byte: one read of the ring memory and the pattern
// memory, then the compare; a plain search or a miss then loads the status word.
// After a hit in extract mode every result word, the status word included, goes
// through one ring memory read, then the stop and limit check.
// Reset clears the pointers and the byte count; neither memory is cleared.
// rx is held off while a search runs; a stalled tx freezes the search at its next word.

module ring_buffer_pattern_search #(
	parameter int RING_DEPTH  = rbps_pkg::RING_DEPTH_DEF,
	parameter int PATTERN_MAX = rbps_pkg::PATTERN_MAX_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rbps_in_if.sink    rx,
	rbps_out_if.source tx
);

	localparam int AW = $clog2(RING_DEPTH);
	localparam int PW = $clog2(PATTERN_MAX);

	logic          ring_we;
	logic [AW-1:0] ring_waddr;
	logic [7:0]    ring_wdata;
	logic [AW-1:0] ring_raddr;
	logic [7:0]    ring_rdata;
	logic          pat_we;
	logic [PW-1:0] pat_waddr;
	logic [7:0]    pat_wdata;
	logic [PW-1:0] pat_raddr;
	logic [7:0]    pat_rdata;

	rbps_ctrl #(
		.RING_DEPTH  (RING_DEPTH),
		.PATTERN_MAX (PATTERN_MAX)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.tx         (tx),
		.ring_we    (ring_we),
		.ring_waddr (ring_waddr),
		.ring_wdata (ring_wdata),
		.ring_raddr (ring_raddr),
		.ring_rdata (ring_rdata),
		.pat_we     (pat_we),
		.pat_waddr  (pat_waddr),
		.pat_wdata  (pat_wdata),
		.pat_raddr  (pat_raddr),
		.pat_rdata  (pat_rdata)
	);

	rbps_ram #(
		.DEPTH (RING_DEPTH),
		.WIDTH (8)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata (ring_wdata),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	rbps_ram #(
		.DEPTH (PATTERN_MAX),
		.WIDTH (8)
	) u_pattern (
		.clk   (clk),
		.we    (pat_we),
		.waddr (pat_waddr),
		.wdata (pat_wdata),
		.raddr (pat_raddr),
		.rdata (pat_rdata)
	);

endmodule

`default_nettype wire

[sv/rbps_ram.sv]
`default_nettype none

module rbps_ram #(
	parameter int DEPTH = rbps_pkg::RING_DEPTH_DEF,
	parameter int WIDTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[sv/rbps_ctrl.sv]
`default_nettype none

module rbps_ctrl #(
	parameter int RING_DEPTH  = rbps_pkg::RING_DEPTH_DEF,
	parameter int PATTERN_MAX = rbps_pkg::PATTERN_MAX_DEF,
	localparam int AW = $clog2(RING_DEPTH),
	localparam int PW = $clog2(PATTERN_MAX)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	rbps_in_if.sink            rx,
	rbps_out_if.source         tx,
	output logic               ring_we,
	output logic [AW-1:0]      ring_waddr,
	output logic [7:0]         ring_wdata,
	output logic [AW-1:0]      ring_raddr,
	input  wire logic [7:0]    ring_rdata,
	output logic               pat_we,
	output logic [PW-1:0]      pat_waddr,
	output logic [7:0]         pat_wdata,
	output logic [PW-1:0]      pat_raddr,
	input  wire logic [7:0]    pat_rdata
);

	localparam int CW = $clog2(RING_DEPTH + 1);
	localparam int CX = CW + 1;
	localparam logic [AW-1:0] LAST = AW'(RING_DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(RING_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_CMP,
		S_EMIT,
		S_XRD,
		S_XCHK
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       wp_q;
	logic [CW-1:0]       cnt_q;
	logic [4:0]          plen_q;
	logic [7:0]          stop_q;
	logic [5:0]          limit_q;
	logic                extract_q;
	logic [AW-1:0]       s_q;
	logic [AW-1:0]       j_q;
	logic [CW-1:0]       t_q;
	logic [4:0]          k_q;
	logic [5:0]          q_q;
	rbps_pkg::result_t   pend_q;
	rbps_pkg::result_t   out_q;
	logic                ovalid_q;

	logic                accept;
	logic                can_load;
	logic                emit_now;
	logic                match_now;
	logic                last_k;
	logic [CX-1:0]       t_next;
	logic                more;
	logic                cont;
	logic                plen_ok;
	logic [CX-1:0]       wp_ext;
	logic [CX-1:0]       plen_ext;
	logic [CX-1:0]       s0_full;
	logic [AW-1:0]       s0;
	logic [31:0]         s_ext;
	logic [31:0]         slot_ext;
	logic [31:0]         k_ext;
	rbps_pkg::result_t   xfer_item;
	rbps_pkg::result_t   pay_item;
	rbps_pkg::result_t   miss_item;
	rbps_pkg::result_t   hit_item;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] v);
		return (v == LAST) ? '0 : AW'(v + 1'b1);
	endfunction

	function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] v);
		return (v == '0) ? LAST : AW'(v - 1'b1);
	endfunction

	assign rx.ready  = (state_q == S_IDLE);
	assign accept    = rx.valid && rx.ready;
	assign can_load  = !ovalid_q || tx.ready;
	assign emit_now  = ((state_q == S_EMIT) || (state_q == S_XCHK)) && can_load;

	assign match_now = (ring_rdata == pat_rdata);
	assign last_k    = (k_q == 5'(plen_q - 5'd1));
	assign t_next    = CX'(t_q) + CX'(1);
	assign more      = (t_next + CX'(plen_q)) <= CX'(cnt_q);
	assign cont      = (q_q < limit_q) && (CX'(q_q) < CX'(t_q)) && (ring_rdata != stop_q);

	// first candidate start: newest position a pattern of this length fits
	assign wp_ext    = CX'(wp_q);
	assign plen_ext  = CX'(rx.pattern_length);
	assign s0_full   = (wp_ext >= plen_ext) ? wp_ext - plen_ext
		: wp_ext + CX'(RING_DEPTH) - plen_ext;
	assign s0        = s0_full[AW-1:0];
	assign plen_ok   = (rx.pattern_length != 5'd0)
		&& (32'(rx.pattern_length) <= 32'(PATTERN_MAX))
		&& (plen_ext <= CX'(cnt_q));

	assign s_ext     = 32'(s_q);
	assign slot_ext  = 32'(rx.pattern_slot);
	assign k_ext     = 32'(k_q);

	assign ring_we    = accept && (rx.action == rbps_pkg::ACT_RECV);
	assign ring_waddr = wp_q;
	assign ring_wdata = rx.data_value;
	assign ring_raddr = j_q;
	assign pat_we     = accept && (rx.action == rbps_pkg::ACT_PATTERN)
		&& (slot_ext < 32'(PATTERN_MAX));
	assign pat_waddr  = slot_ext[PW-1:0];
	assign pat_wdata  = rx.data_value;
	assign pat_raddr  = k_ext[PW-1:0];

	always_comb begin
		xfer_item = pend_q;
		xfer_item.final_item = !cont;
	end

	assign pay_item  = '{found: 1'b1, match_position: pend_q.match_position,
		is_payload: 1'b1, payload_byte: ring_rdata, final_item: 1'b1};
	assign miss_item = '{found: 1'b0, match_position: 8'd0, is_payload: 1'b0,
		payload_byte: 8'd0, final_item: 1'b1};
	assign hit_item  = '{found: 1'b1, match_position: s_ext[7:0], is_payload: 1'b0,
		payload_byte: 8'd0, final_item: 1'b1};

	assign tx.valid          = ovalid_q;
	assign tx.found          = out_q.found;
	assign tx.match_position = out_q.match_position;
	assign tx.is_payload     = out_q.is_payload;
	assign tx.payload_byte   = out_q.payload_byte;
	assign tx.final_item     = out_q.final_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			wp_q      <= '0;
			cnt_q     <= '0;
			ovalid_q  <= 1'b0;
			plen_q    <= '0;
			stop_q    <= '0;
			limit_q   <= '0;
			extract_q <= 1'b0;
			s_q       <= '0;
			j_q       <= '0;
			t_q       <= '0;
			k_q       <= '0;
			q_q       <= '0;
			pend_q    <= '0;
			out_q     <= '0;
		end else begin
			if (ovalid_q && tx.ready && !emit_now) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (rx.action)
							rbps_pkg::ACT_RECV: begin
								wp_q <= wrap_inc(wp_q);
								if (cnt_q != FULL) begin
									cnt_q <= CW'(cnt_q + 1'b1);
								end
							end
							rbps_pkg::ACT_PURGE: begin
								cnt_q <= '0;
							end
							rbps_pkg::ACT_SEARCH, rbps_pkg::ACT_EXTRACT: begin
								plen_q    <= rx.pattern_length;
								stop_q    <= rx.stop_byte;
								limit_q   <= rx.copy_limit;
								extract_q <= (rx.action == rbps_pkg::ACT_EXTRACT);
								t_q       <= '0;
								k_q       <= '0;
								s_q       <= s0;
								j_q       <= s0;
								if (plen_ok) begin
									state_q <= S_RD;
								end else begin
									pend_q  <= miss_item;
									state_q <= S_EMIT;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (match_now) begin
						j_q <= wrap_inc(j_q);
						if (last_k) begin
							pend_q  <= hit_item;
							q_q     <= '0;
							state_q <= extract_q ? S_XRD : S_EMIT;
						end else begin
							k_q     <= 5'(k_q + 5'd1);
							state_q <= S_RD;
						end
					end else if (more) begin
						// step back one start position, restart the pattern
						t_q     <= t_next[CW-1:0];
						k_q     <= '0;
						s_q     <= wrap_dec(s_q);
						j_q     <= wrap_dec(s_q);
						state_q <= S_RD;
					end else begin
						pend_q  <= miss_item;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (can_load) begin
						out_q    <= pend_q;
						ovalid_q <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_XRD: begin
					state_q <= S_XCHK;
				end
				S_XCHK: begin
					// hold the pending word until the next byte says if it is the last
					if (can_load) begin
						out_q    <= xfer_item;
						ovalid_q <= 1'b1;
						if (cont) begin
							pend_q  <= pay_item;
							q_q     <= 6'(q_q + 6'd1);
							j_q     <= wrap_inc(j_q);
							state_q <= S_XRD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
